### hw/rtl/src_pkg.sv
// Package for the stored record checker: phase and status codes, header
// layout constants and the bytewise CRC-16/CCITT-FALSE update function.
// Has no dependencies.
package src_pkg;

	localparam int unsigned PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;
	localparam logic [PHASE_W-1:0] PH_DONE    = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_EMPTY       = 3'd1;
	localparam status_t ST_BAD_MAGIC   = 3'd2;
	localparam status_t ST_BAD_VERSION = 3'd3;
	localparam status_t ST_BAD_LENGTH  = 3'd4;
	localparam status_t ST_BAD_CRC     = 3'd5;

	localparam logic [3:0]  HDR_LAST_INDEX = 4'd11;
	localparam logic [31:0] RECORD_MAGIC   = 32'h3244_5045;
	localparam logic [31:0] ERASED_MAGIC   = 32'hFFFF_FFFF;
	localparam logic [15:0] STORE_MAX      = 16'd3072;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'h1021;

	localparam int unsigned COUNT_W = 12;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hw/rtl/stored_record_checker.sv
// Top level of the stored record checker: input register, record state and
// result register. Depends on src_pkg for codes, constants and the CRC update.
//
// The checker takes one record byte per item and gives one status item per
// record: after the twelfth header byte when the header fails (erased, bad
// magic, bad version or bad length, in that order), else after the last
// payload byte (ok or bad CRC). It accepts one byte every clock cycle unless
// the result register holds an item that is not taken; a byte passes an input
// register and its status is then written to the result register. The CRC of
// each byte is computed combinationally. A byte with first_byte set restarts
// the checker at any time. Bytes that arrive while no record is open give no
// item.
module stored_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] status, [18:3] record_length, [23:19] zero
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic CFG_VERSION = 1'b0;
	localparam logic CFG_LIMIT   = 1'b1;

	logic [15:0] expected_version_q;
	logic [15:0] length_limit_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;

	logic [src_pkg::PHASE_W-1:0] phase_q;
	logic [3:0]                  header_index_q;
	logic [31:0]                 magic_q;
	logic [15:0]                 version_q;
	logic [15:0]                 payload_length_q;
	logic [15:0]                 stored_crc_q;
	logic [15:0]                 running_crc_q;
	logic [src_pkg::COUNT_W-1:0] payload_count_q;

	logic              valid_s2;
	src_pkg::status_t  status_s2;
	logic [15:0]       length_s2;

	logic                        advance;
	logic [src_pkg::PHASE_W-1:0] cur_phase;
	logic [3:0]                  cur_index;
	logic [15:0]                 cur_crc;
	logic [src_pkg::COUNT_W-1:0] cur_count;
	logic [15:0]                 new_crc;
	logic [src_pkg::COUNT_W:0]   new_count;
	logic                        length_bad;
	logic [src_pkg::PHASE_W-1:0] next_phase;
	logic                        res_valid;
	src_pkg::status_t            res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= 16'd2;
			length_limit_q     <= 16'd3072;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERSION: expected_version_q <= cfg_data;
				CFG_LIMIT:   length_limit_q     <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	assign cur_phase = first_s1 ? src_pkg::PH_HEADER : phase_q;
	assign cur_index = first_s1 ? 4'd0 : header_index_q;
	assign cur_crc   = first_s1 ? src_pkg::CRC_INIT : running_crc_q;
	assign cur_count = first_s1 ? '0 : payload_count_q;
	assign new_crc   = src_pkg::crc_byte(cur_crc, byte_s1);
	assign new_count = {1'b0, cur_count} + 1'b1;

	assign length_bad = (payload_length_q == 16'd0) || (payload_length_q > length_limit_q) ||
		(payload_length_q > src_pkg::STORE_MAX);

	always_comb begin
		next_phase = cur_phase;
		res_valid  = 1'b0;
		res_status = src_pkg::ST_OK;
		unique case (cur_phase)
			src_pkg::PH_HEADER: begin
				if (cur_index == src_pkg::HDR_LAST_INDEX) begin
					res_valid  = 1'b1;
					next_phase = src_pkg::PH_DONE;
					priority if (magic_q == src_pkg::ERASED_MAGIC) begin
						res_status = src_pkg::ST_EMPTY;
					end else if (magic_q != src_pkg::RECORD_MAGIC) begin
						res_status = src_pkg::ST_BAD_MAGIC;
					end else if (version_q != expected_version_q) begin
						res_status = src_pkg::ST_BAD_VERSION;
					end else if (length_bad) begin
						res_status = src_pkg::ST_BAD_LENGTH;
					end else begin
						res_valid  = 1'b0;
						next_phase = src_pkg::PH_PAYLOAD;
					end
				end
			end
			src_pkg::PH_PAYLOAD: begin
				if ({3'b000, new_count} >= payload_length_q) begin
					res_valid  = 1'b1;
					next_phase = src_pkg::PH_DONE;
					res_status = (new_crc == stored_crc_q) ? src_pkg::ST_OK : src_pkg::ST_BAD_CRC;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= src_pkg::PH_IDLE;
			header_index_q  <= 4'd0;
			running_crc_q   <= src_pkg::CRC_INIT;
			payload_count_q <= '0;
		end else if (advance) begin
			phase_q <= next_phase;
			if (first_s1) begin
				running_crc_q   <= src_pkg::CRC_INIT;
				payload_count_q <= '0;
			end
			if (cur_phase == src_pkg::PH_HEADER) begin
				header_index_q <= cur_index + 4'd1;
			end
			if (cur_phase == src_pkg::PH_PAYLOAD) begin
				running_crc_q   <= new_crc;
				payload_count_q <= new_count[src_pkg::COUNT_W-1:0];
			end
		end
	end

	// Header fields are fully overwritten before the header decision.
	always_ff @(posedge clk) begin
		if (advance && cur_phase == src_pkg::PH_HEADER) begin
			unique case (cur_index)
				4'd0:    magic_q[7:0]            <= byte_s1;
				4'd1:    magic_q[15:8]           <= byte_s1;
				4'd2:    magic_q[23:16]          <= byte_s1;
				4'd3:    magic_q[31:24]          <= byte_s1;
				4'd4:    version_q[7:0]          <= byte_s1;
				4'd5:    version_q[15:8]         <= byte_s1;
				4'd6:    payload_length_q[7:0]   <= byte_s1;
				4'd7:    payload_length_q[15:8]  <= byte_s1;
				4'd8:    stored_crc_q[7:0]       <= byte_s1;
				4'd9:    stored_crc_q[15:8]      <= byte_s1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			status_s2 <= res_status;
			length_s2 <= (res_status == src_pkg::ST_OK) ? payload_length_q : 16'd0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, length_s2, status_s2};

`ifndef ASSERT_OFF
	a_len_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] != src_pkg::ST_OK) |-> m_tdata[18:3] == 16'd0)
		else $error("failing status carries a nonzero record length");

	a_ok_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == src_pkg::ST_OK) |->
		(m_tdata[18:3] != 16'd0 && m_tdata[18:3] <= src_pkg::STORE_MAX))
		else $error("ok status with a record length out of range");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == src_pkg::PH_PAYLOAD) |-> {4'd0, payload_count_q} < payload_length_q)
		else $error("payload count reached the length without a decision");

	a_header_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == src_pkg::PH_HEADER) |-> header_index_q <= src_pkg::HDR_LAST_INDEX)
		else $error("header index ran past the header");
`endif

endmodule
